@@ rtl/facat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag store package
// Widths and shared types of the fully associative FIFO-replacement tag store.
// ----------------------------------------------------------------------------
package facat_pkg;

    localparam int ADDR_W    = 32;  // width of the address field
    localparam int OFF_W     = 5;   // width of the offset register
    localparam int IDX_OUT_W = 4;   // width of the entry_index field
    localparam int CNT_W     = 32;  // width of the hit and miss counters

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Per-cell strobes from the sequencer.
    typedef struct packed {
        logic cmp;
        logic wr;
    } t_cell_ctrl;

    typedef struct packed {
        logic                 hit;
        logic [IDX_OUT_W-1:0] entry_index;
        logic [CNT_W-1:0]     hits_so_far;
        logic [CNT_W-1:0]     misses_so_far;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/facat_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag store channels
// Valid/ready channels for access items and result items.
// ----------------------------------------------------------------------------
interface facat_in_if;
    import facat_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface facat_out_if;
    import facat_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CNT_W-1:0]     hits_so_far;
    logic [CNT_W-1:0]     misses_so_far;

    modport source (output valid, output hit, output entry_index,
                    output hits_so_far, output misses_so_far, input ready);
    modport sink   (input valid, input hit, input entry_index,
                    input hits_so_far, input misses_so_far, output ready);
endinterface
`default_nettype wire

@@ rtl/fully_assoc_fifo_cache_tags.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The access item is taken in S_IDLE, where its tag is loaded, is compared in the
// cell row in S_CMP and is resolved in S_UPD, where the result item is registered;
// S_UPD waits while the previous result is still waiting at the output.
// One item is looked up at a time; the next item is taken while a result waits.
// Reset (synchronous, active low) clears valid bits, fill pointer, counters
// and the offset register; stored tags are not cleared.
// ----------------------------------------------------------------------------
// Fully associative tag store with FIFO replacement
// A row of tag cells searched in parallel, with a round-robin fill pointer
// and saturating hit and miss counters.
// ----------------------------------------------------------------------------
module fully_assoc_fifo_cache_tags #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    facat_in_if.sink                  i_addr,
    facat_out_if.source               o_res,
    input  wire                       i_cfg_wr_en,
    input  wire [facat_pkg::OFF_W-1:0] i_cfg_wr_data
);
    import facat_pkg::*;

    localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((64'd1 << TAG_W) - 64'd1);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} t_state;

    t_state             r_state;
    logic [OFF_W-1:0]   r_offset;
    logic [TAG_W-1:0]   r_tag;
    logic [IDX_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_misses;
    logic               r_out_valid;
    t_result            r_out;

    t_cell_ctrl         cell_ctrl [ENTRIES];
    logic [ENTRIES:0]   found_chain;
    logic [ENTRIES-1:0] first;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   slot;
    logic [31:0]        slot_ext;
    logic               hit;
    logic               in_fire;
    logic               upd_fire;
    logic [ADDR_W-1:0]  shifted;

    assign in_fire  = i_addr.valid && i_addr.ready;
    assign upd_fire = (r_state == S_UPD) && (!r_out_valid || o_res.ready);
    assign shifted  = (i_addr.address & ADDR_MASK) >> r_offset;

    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign cell_ctrl[g].cmp = (r_state == S_CMP);
        assign cell_ctrl[g].wr  = upd_fire && !hit && (r_ptr == IDX_W'(g));

        facat_cell #(.TAG_W(TAG_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl[g]),
            .i_tag   (r_tag),
            .i_found (found_chain[g]),
            .o_found (found_chain[g+1]),
            .o_first (first[g])
        );
    end

    assign hit = found_chain[ENTRIES];

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (first[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign slot     = hit ? hit_idx : r_ptr;
    assign slot_ext = 32'(slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            r_offset <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tag <= shifted[TAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_fire) begin
                        r_state     <= S_IDLE;
                        r_out.hit         <= hit;
                        r_out.entry_index <= slot_ext[IDX_OUT_W-1:0];
                        if (hit) begin
                            r_out.hits_so_far   <= (r_hits == CNT_MAX) ? r_hits
                                                                       : r_hits + 1'b1;
                            r_out.misses_so_far <= r_misses;
                            r_hits <= (r_hits == CNT_MAX) ? r_hits : r_hits + 1'b1;
                        end else begin
                            r_out.hits_so_far   <= r_hits;
                            r_out.misses_so_far <= (r_misses == CNT_MAX) ? r_misses
                                                                         : r_misses + 1'b1;
                            r_misses <= (r_misses == CNT_MAX) ? r_misses
                                                              : r_misses + 1'b1;
                            r_ptr <= (r_ptr == IDX_W'(ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_addr.ready        = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.hit           = r_out.hit;
    assign o_res.entry_index   = r_out.entry_index;
    assign o_res.hits_so_far   = r_out.hits_so_far;
    assign o_res.misses_so_far = r_out.misses_so_far;

endmodule
`default_nettype wire

@@ rtl/facat_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag store cell
// Holds one tag and its valid bit, compares against the broadcast tag and
// passes the "match found below" flag on to the next cell of the row.
// ----------------------------------------------------------------------------
module facat_cell #(
    parameter int TAG_W = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  facat_pkg::t_cell_ctrl i_ctrl,
    input  wire [TAG_W-1:0]       i_tag,
    input  wire                   i_found,
    output logic                  o_found,
    output logic                  o_first
);
    import facat_pkg::*;

    logic             r_valid;
    logic [TAG_W-1:0] r_tag;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.wr) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_tag <= i_tag;
        end
        if (i_ctrl.cmp) begin
            r_match <= r_valid && (r_tag == i_tag);
        end
    end

    // Only the lowest-numbered matching cell claims the hit.
    assign o_first = r_match && !i_found;
    assign o_found = r_match || i_found;

endmodule
`default_nettype wire

@@ rtl/facat_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag store checker
// Port-level assertions on the tag store, attached to the top level by bind.
// ----------------------------------------------------------------------------
module facat_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             i_in_ready,
    input wire                             i_out_valid,
    input wire                             i_out_ready,
    input wire                             i_hit,
    input wire [facat_pkg::IDX_OUT_W-1:0]  i_entry_index,
    input wire [facat_pkg::CNT_W-1:0]      i_hits,
    input wire [facat_pkg::CNT_W-1:0]      i_misses
);
    import facat_pkg::*;

    // One item is looked up at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item taken while a lookup is in progress");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item shown straight after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_hit) && $stable(i_entry_index)
             && $stable(i_hits) && $stable(i_misses)))
        else $error("stalled result item changed");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_hit) |-> (i_hits != '0))
        else $error("hit reported with zero hit count");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_hit) |-> (i_misses != '0))
        else $error("miss reported with zero miss count");

endmodule

bind fully_assoc_fifo_cache_tags facat_chk u_facat_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_addr.valid),
    .i_in_ready    (i_addr.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_hit         (o_res.hit),
    .i_entry_index (o_res.entry_index),
    .i_hits        (o_res.hits_so_far),
    .i_misses      (o_res.misses_so_far)
);
`default_nettype wire
